FILE: rtl/core/bfas_pkg.sv
package bfas_pkg;

    localparam logic [3:0] JOB_COUNT_RESET = 4'd4;

    // microcode step addresses, in program order
    typedef enum logic [3:0] {
        ST_INIT,
        ST_ENTER,
        ST_PUSH,
        ST_SW_A,
        ST_SW_B,
        ST_EV_RD,
        ST_EV_ACC,
        ST_EV_CMP,
        ST_RET,
        ST_UN_A,
        ST_UN_B,
        ST_INC,
        ST_CLR,
        ST_OUT_INIT,
        ST_OUT_EMIT,
        ST_HALT
    } t_step;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_INIT,
        OP_CLR_SUM,
        OP_PUSH,
        OP_SWAP_A,
        OP_SWAP_B,
        OP_RD,
        OP_ACC,
        OP_CMP,
        OP_POP,
        OP_INC,
        OP_IDX_CLR,
        OP_P_CLR,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        CND_NONE,
        CND_ALWAYS,
        CND_LEAF,
        CND_P_MORE,
        CND_IDX_MORE,
        CND_LVL_ZERO
    } t_cond;

    typedef struct packed {
        t_op   op;
        logic  lvl_up;
        t_cond cond;
        t_step target;
    } t_ctrl;

    typedef struct packed {
        logic leaf;
        logic p_more;
        logic idx_more;
        logic lvl_zero;
    } t_status;

    // control store
    function automatic t_ctrl ucode(input t_step s);
        t_ctrl w;
        w = '{op: OP_NOP, lvl_up: 1'b0, cond: CND_NONE, target: ST_INIT};
        case (s)
            ST_INIT: w.op = OP_INIT;
            ST_ENTER: begin
                w.op     = OP_CLR_SUM;
                w.cond   = CND_LEAF;
                w.target = ST_EV_RD;
            end
            ST_PUSH: w.op = OP_PUSH;
            ST_SW_A: w.op = OP_SWAP_A;
            ST_SW_B: begin
                w.op     = OP_SWAP_B;
                w.lvl_up = 1'b1;
                w.cond   = CND_ALWAYS;
                w.target = ST_ENTER;
            end
            ST_EV_RD: w.op = OP_RD;
            ST_EV_ACC: begin
                w.op     = OP_ACC;
                w.cond   = CND_P_MORE;
                w.target = ST_EV_RD;
            end
            ST_EV_CMP: w.op = OP_CMP;
            ST_RET: begin
                w.op     = OP_POP;
                w.cond   = CND_LVL_ZERO;
                w.target = ST_OUT_INIT;
            end
            ST_UN_A: w.op = OP_SWAP_A;
            ST_UN_B: w.op = OP_SWAP_B;
            ST_INC: begin
                w.op     = OP_INC;
                w.cond   = CND_IDX_MORE;
                w.target = ST_SW_A;
            end
            ST_CLR: begin
                w.op     = OP_IDX_CLR;
                w.cond   = CND_ALWAYS;
                w.target = ST_RET;
            end
            ST_OUT_INIT: w.op = OP_P_CLR;
            ST_OUT_EMIT: begin
                w.op     = OP_EMIT;
                w.cond   = CND_P_MORE;
                w.target = ST_OUT_EMIT;
            end
            ST_HALT: w.op = OP_NOP;
            default: w.op = OP_NOP;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/brute_force_assignment_search.sv
// Exhaustive assignment search. Cost words are written one per cycle while busy is low;
// a word with i_last_entry set is stored and starts the search over all n! job orders,
// n being the job count register limited to 1..MAX_JOBS. The search runs on a small
// microcoded sequencer and reads the cost store once per person per order. Then n words
// are reported one per cycle, one per person, each marked by o_strobe for a single cycle.
// Busy stays high throughout, including the cycle of the last word, and falls in the
// cycle after it. The receiver cannot hold results off: take each word in the cycle it is
// shown. Write the job count only while busy is low.
module brute_force_assignment_search #(
    parameter int MAX_JOBS  = 8,
    parameter int COST_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [2:0]  i_job_index,
    input  logic [2:0]  i_person_index,
    input  logic [15:0] i_cost,
    input  logic        i_last_entry,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    output logic        busy,
    output logic        o_strobe,
    output logic [2:0]  o_person_slot,
    output logic [2:0]  o_assigned_job,
    output logic [18:0] o_min_total_cost,
    output logic [15:0] o_permutations_checked,
    output logic        o_last_result
);

    localparam int DEPTH = MAX_JOBS * MAX_JOBS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(MAX_JOBS + 1);

    logic [3:0]              r_job_count;
    logic [NW-1:0]           w_side;
    logic                    w_accept;
    logic                    w_in_range;
    logic                    w_we;
    logic                    w_go;
    logic [AW-1:0]           w_waddr;
    logic [COST_BITS+15:0]   w_cost_ext;
    logic                    w_rd_en;
    logic [AW-1:0]           w_rd_addr;
    logic [COST_BITS-1:0]    w_rd_data;
    bfas_pkg::t_ctrl         w_ctrl;
    bfas_pkg::t_status       w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_count <= bfas_pkg::JOB_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_job_count <= i_cfg_wdata;
        end
    end

    // clamp the side in use to 1..MAX_JOBS
    always_comb begin
        if (r_job_count == 4'd0) begin
            w_side = NW'(1);
        end else if (32'(r_job_count) > MAX_JOBS) begin
            w_side = NW'(MAX_JOBS);
        end else begin
            w_side = NW'(r_job_count);
        end
    end

    assign w_accept   = start && !busy;
    assign w_in_range = (32'(i_job_index) < MAX_JOBS) && (32'(i_person_index) < MAX_JOBS);
    assign w_we       = w_accept && w_in_range;
    assign w_go       = w_accept && i_last_entry;
    assign w_waddr    = AW'(32'(i_job_index) * MAX_JOBS + 32'(i_person_index));
    assign w_cost_ext = {{COST_BITS{1'b0}}, i_cost};

    bfas_ram #(
        .WIDTH (COST_BITS),
        .DEPTH (DEPTH)
    ) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_cost_ext[COST_BITS-1:0]),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    bfas_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_status (w_status),
        .o_ctrl   (w_ctrl),
        .o_busy   (busy)
    );

    bfas_datapath #(
        .MAX_JOBS  (MAX_JOBS),
        .COST_BITS (COST_BITS)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_ctrl                 (w_ctrl),
        .i_go                   (w_go),
        .i_side                 (w_side),
        .o_status               (w_status),
        .o_rd_en                (w_rd_en),
        .o_rd_addr              (w_rd_addr),
        .i_rd_data              (w_rd_data),
        .o_strobe               (o_strobe),
        .o_person_slot          (o_person_slot),
        .o_assigned_job         (o_assigned_job),
        .o_min_total_cost       (o_min_total_cost),
        .o_permutations_checked (o_permutations_checked),
        .o_last_result          (o_last_result)
    );

endmodule

FILE: rtl/core/bfas_ram.sv
module bfas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/bfas_sequencer.sv
module bfas_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  bfas_pkg::t_status i_status,
    output bfas_pkg::t_ctrl   o_ctrl,
    output logic             o_busy
);

    bfas_pkg::t_step r_step;
    bfas_pkg::t_step n_step;
    logic            r_run;
    logic            n_run;
    bfas_pkg::t_ctrl w_word;
    logic            w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= bfas_pkg::ST_INIT;
            r_run  <= 1'b0;
        end else begin
            r_step <= n_step;
            r_run  <= n_run;
        end
    end

    always_comb begin
        w_word = bfas_pkg::ucode(r_step);
        case (w_word.cond)
            bfas_pkg::CND_ALWAYS:   w_take = 1'b1;
            bfas_pkg::CND_LEAF:     w_take = i_status.leaf;
            bfas_pkg::CND_P_MORE:   w_take = i_status.p_more;
            bfas_pkg::CND_IDX_MORE: w_take = i_status.idx_more;
            bfas_pkg::CND_LVL_ZERO: w_take = i_status.lvl_zero;
            default:                w_take = 1'b0;
        endcase

        n_step = r_step;
        n_run  = r_run;
        if (!r_run) begin
            if (i_go) begin
                n_step = bfas_pkg::ST_INIT;
                n_run  = 1'b1;
            end
        end else if (r_step == bfas_pkg::ST_HALT) begin
            n_run = 1'b0;
        end else if (w_take) begin
            n_step = w_word.target;
        end else begin
            n_step = bfas_pkg::t_step'(4'(r_step) + 4'd1);
        end

        o_ctrl = w_word;
        if (!r_run) begin
            o_ctrl.op     = bfas_pkg::OP_NOP;
            o_ctrl.lvl_up = 1'b0;
        end
    end

    assign o_busy = r_run;

endmodule

FILE: rtl/core/bfas_datapath.sv
module bfas_datapath #(
    parameter int MAX_JOBS  = 8,
    parameter int COST_BITS = 16,
    localparam int AW = (MAX_JOBS * MAX_JOBS > 1) ? $clog2(MAX_JOBS * MAX_JOBS) : 1,
    localparam int NW = $clog2(MAX_JOBS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bfas_pkg::t_ctrl      i_ctrl,
    input  logic                 i_go,
    input  logic [NW-1:0]        i_side,
    output bfas_pkg::t_status    o_status,
    output logic                 o_rd_en,
    output logic [AW-1:0]        o_rd_addr,
    input  logic [COST_BITS-1:0] i_rd_data,
    output logic                 o_strobe,
    output logic [2:0]           o_person_slot,
    output logic [2:0]           o_assigned_job,
    output logic [18:0]          o_min_total_cost,
    output logic [15:0]          o_permutations_checked,
    output logic                 o_last_result
);

    localparam int IW    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int TOT_W = COST_BITS + $clog2(MAX_JOBS);

    logic [IW-1:0]    r_perm      [MAX_JOBS];
    logic [IW-1:0]    r_idx       [MAX_JOBS];
    logic [IW-1:0]    r_best_perm [MAX_JOBS];
    logic [IW-1:0]    r_lvl;
    logic [IW-1:0]    r_p;
    logic [IW-1:0]    r_tmp;
    logic [NW-1:0]    r_n;
    logic [TOT_W-1:0] r_sum;
    logic [TOT_W-1:0] r_best;
    logic             r_have;
    logic [15:0]      r_cnt;

    logic             r_o_strobe;
    logic [2:0]       r_o_slot;
    logic [2:0]       r_o_job;
    logic [18:0]      r_o_total;
    logic [15:0]      r_o_cnt;
    logic             r_o_last;

    logic [IW-1:0]    w_cur;
    logic             w_better;
    logic [IW+2:0]    w_slot_ext;
    logic [IW+2:0]    w_job_ext;
    logic [TOT_W+18:0] w_total_ext;

    assign w_cur    = r_idx[r_lvl];
    assign w_better = !r_have || (r_sum < r_best);

    assign w_slot_ext  = {3'b000, r_p};
    assign w_job_ext   = {3'b000, r_best_perm[r_p]};
    assign w_total_ext = {19'd0, r_best};

    assign o_status.leaf     = (32'(r_lvl) + 1) >= 32'(r_n);
    assign o_status.p_more   = (32'(r_p) + 1) < 32'(r_n);
    assign o_status.idx_more = (32'(w_cur) + 1) < 32'(r_n);
    assign o_status.lvl_zero = (r_lvl == '0);

    // cost of job perm[p] given to person p
    assign o_rd_en   = (i_ctrl.op == bfas_pkg::OP_RD);
    assign o_rd_addr = AW'(32'(r_perm[r_p]) * MAX_JOBS + 32'(r_p));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl      <= '0;
            r_p        <= '0;
            r_have     <= 1'b0;
            r_cnt      <= '0;
            r_o_strobe <= 1'b0;
        end else begin
            r_o_strobe <= (i_ctrl.op == bfas_pkg::OP_EMIT);
            case (i_ctrl.op)
                bfas_pkg::OP_INIT: begin
                    r_lvl  <= '0;
                    r_have <= 1'b0;
                    r_cnt  <= '0;
                end
                bfas_pkg::OP_CLR_SUM: r_p <= '0;
                bfas_pkg::OP_ACC:     r_p <= r_p + 1'b1;
                bfas_pkg::OP_CMP: begin
                    r_have <= 1'b1;
                    r_cnt  <= r_cnt + 16'd1;
                end
                bfas_pkg::OP_POP: begin
                    if (r_lvl != '0) begin
                        r_lvl <= r_lvl - 1'b1;
                    end
                end
                bfas_pkg::OP_P_CLR: r_p <= '0;
                bfas_pkg::OP_EMIT:  r_p <= r_p + 1'b1;
                default: ;
            endcase
            if (i_ctrl.lvl_up) begin
                r_lvl <= r_lvl + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_n <= i_side;
        end
        case (i_ctrl.op)
            bfas_pkg::OP_INIT: begin
                for (int k = 0; k < MAX_JOBS; k++) begin
                    r_perm[k] <= IW'(k);
                    r_idx[k]  <= '0;
                end
                r_best <= '1;
            end
            bfas_pkg::OP_CLR_SUM: r_sum <= '0;
            bfas_pkg::OP_PUSH:    r_idx[r_lvl] <= r_lvl;
            bfas_pkg::OP_SWAP_A:  r_tmp <= r_perm[w_cur];
            bfas_pkg::OP_SWAP_B: begin
                // same slot on both sides leaves it unchanged
                r_perm[w_cur] <= r_perm[r_lvl];
                r_perm[r_lvl] <= r_tmp;
            end
            bfas_pkg::OP_ACC: r_sum <= r_sum + TOT_W'(i_rd_data);
            bfas_pkg::OP_CMP: begin
                // strict compare keeps the earliest cheapest order
                if (w_better) begin
                    r_best <= r_sum;
                    for (int k = 0; k < MAX_JOBS; k++) begin
                        r_best_perm[k] <= r_perm[k];
                    end
                end
            end
            bfas_pkg::OP_INC:     r_idx[r_lvl] <= r_idx[r_lvl] + 1'b1;
            bfas_pkg::OP_IDX_CLR: r_idx[r_lvl] <= '0;
            bfas_pkg::OP_EMIT: begin
                r_o_slot  <= w_slot_ext[2:0];
                r_o_job   <= w_job_ext[2:0];
                r_o_total <= w_total_ext[18:0];
                r_o_cnt   <= r_cnt;
                r_o_last  <= !o_status.p_more;
            end
            default: ;
        endcase
    end

    assign o_strobe               = r_o_strobe;
    assign o_person_slot          = r_o_slot;
    assign o_assigned_job         = r_o_job;
    assign o_min_total_cost       = r_o_total;
    assign o_permutations_checked = r_o_cnt;
    assign o_last_result          = r_o_last;

endmodule
